// ===== src/hfmc_pkg.sv =====
// shared types, constants and hash helpers for the hashed memo cache
`timescale 1ns / 1ps
package hfmc_pkg;

  localparam int SET_BITS   = 8;
  localparam int WAYS       = 4;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SETS       = 1 << SET_BITS;
  localparam int OCC_W      = 11;
  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;
  localparam int HASH_STAGES = 9;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key_prefix;
    logic [63:0] key_suffix;
    logic [63:0] value_low;
    logic [63:0] value_high;
  } item_t;

  typedef struct packed {
    item_t               item;
    logic                key_zero;
    logic [SET_BITS-1:0] set_idx;
    logic [WAY_BITS-1:0] evict_way;
  } queue_item_t;

  // partial products of a 64 x 64 multiply, low 64 bits only
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  typedef struct packed {
    logic [WAYS-1:0][63:0]  tag_first;
    logic [WAYS-1:0][63:0]  tag_second;
    logic [WAYS-1:0][127:0] count;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [63:0]      found_low;
    logic [63:0]      found_high;
    logic             evicted;
    logic [OCC_W-1:0] entries_used;
  } result_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] v, input int sh);
    return v ^ (v >> sh);
  endfunction

  function automatic pp_t mul_pp(input logic [63:0] x, input logic [63:0] c);
    pp_t         p;
    logic [63:0] lh_full;
    logic [63:0] hl_full;
    p.ll    = {32'b0, x[31:0]} * {32'b0, c[31:0]};
    lh_full = {32'b0, x[31:0]} * {32'b0, c[63:32]};
    hl_full = {32'b0, x[63:32]} * {32'b0, c[31:0]};
    p.lh    = lh_full[31:0];
    p.hl    = hl_full[31:0];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'b0};
  endfunction

endpackage

// ===== src/hashed_four_way_memo_cache_top.sv =====
// top level of the hashed four-way memo cache
//
// Input channel (in_valid_i / in_ready_o) takes one word: an opcode (lookup
// or insert), a two-word key and a 128-bit count. Output channel
// (out_valid_o / out_ready_i) returns one word per input word, in order:
// hit, the stored count on a hit, the eviction flag and the occupancy.
// The key is hashed in a nine-stage pipeline; its low bits pick a set of
// four ways held as one memory row. A two-entry queue separates the hash
// pipe from the store sequencer, which reads a row, matches all ways and,
// on an insert, writes the row back.
// The sequencer finishes each word (a read of the single-port set memory
// and, on an insert, the write-back) before it takes the next one; the
// hash pipe takes a word every cycle until the queue fills.
// Reset clears the per-set valid bits (every way reads as empty) and the
// occupancy; no clearing pass is needed. When the receiver stalls the
// result stays in the output register, one more word reads its row behind
// it and waits, and the queue and hash pipe then fill and drop in_ready_o.
`timescale 1ns / 1ps
module hashed_four_way_memo_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [63:0] key_prefix_i,
  input  logic [63:0] key_suffix_i,
  input  logic [63:0] value_low_i,
  input  logic [63:0] value_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [63:0] found_low_o,
  output logic [63:0] found_high_o,
  output logic        evicted_o,
  output logic [10:0] entries_used_o
);
  import hfmc_pkg::*;

  item_t       in_item;
  queue_item_t push_item, pop_item;
  logic        push_valid, push_ready, pop_valid, pop;
  result_t     res;

  always_comb begin
    in_item.op         = op_e'(opcode_i);
    in_item.key_prefix = key_prefix_i;
    in_item.key_suffix = key_suffix_i;
    in_item.value_low  = value_low_i;
    in_item.value_high = value_high_i;
  end

  hfmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  hfmc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  hfmc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .pop_item_i (pop_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (res)
  );

  assign hit_o          = res.hit;
  assign found_low_o    = res.found_low;
  assign found_high_o   = res.found_high;
  assign evicted_o      = res.evicted;
  assign entries_used_o = res.entries_used;

endmodule

// ===== src/hfmc_front.sv =====
// hash pipeline: accepts words, computes the set index and victim way
`timescale 1ns / 1ps
module hfmc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hfmc_pkg::item_t      in_item_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output hfmc_pkg::queue_item_t push_item_o
);
  import hfmc_pkg::*;

  logic [HASH_STAGES-1:0] valid_q;
  item_t                  item_q [HASH_STAGES];
  pp_t                    pp0_q, pp2_q, pp5_q, pp7_q;
  logic [63:0]            w1_q, w3_q, w4_q, w6_q, w8_q;
  logic                   adv;

  // the whole pipe moves unless its last word is stuck
  assign adv          = !valid_q[HASH_STAGES-1] || push_ready_i;
  assign in_ready_o   = adv;
  assign push_valid_o = valid_q[HASH_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[HASH_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= in_item_i;
      for (int s = 1; s < HASH_STAGES; s++) begin
        item_q[s] <= item_q[s-1];
      end
      // inner finalizer on the suffix
      pp0_q <= mul_pp(xor_shift(in_item_i.key_suffix, SHIFT_A), MIX_C1);
      w1_q  <= xor_shift(mul_sum(pp0_q), SHIFT_B);
      pp2_q <= mul_pp(w1_q, MIX_C2);
      w3_q  <= xor_shift(mul_sum(pp2_q), SHIFT_C);
      // fold in the prefix, then the outer finalizer
      w4_q  <= xor_shift(item_q[3].key_prefix ^ (w3_q + GOLDEN), SHIFT_A);
      pp5_q <= mul_pp(w4_q, MIX_C1);
      w6_q  <= xor_shift(mul_sum(pp5_q), SHIFT_B);
      pp7_q <= mul_pp(w6_q, MIX_C2);
      w8_q  <= xor_shift(mul_sum(pp7_q), SHIFT_C);
    end
  end

  logic [31:0] hash_hi;
  assign hash_hi = w8_q[63:32];

  always_comb begin
    push_item_o.item      = item_q[HASH_STAGES-1];
    push_item_o.key_zero  = (item_q[HASH_STAGES-1].key_prefix == 64'd0);
    push_item_o.set_idx   = w8_q[SET_BITS-1:0];
    push_item_o.evict_way = WAY_BITS'(hash_hi % WAYS);
  end

endmodule

// ===== src/hfmc_fifo.sv =====
// two-entry queue between the hash pipe and the store sequencer
`timescale 1ns / 1ps
module hfmc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  hfmc_pkg::queue_item_t push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output hfmc_pkg::queue_item_t pop_item_o
);
  import hfmc_pkg::*;

  queue_item_t           ent_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = ent_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== src/hfmc_back.sv =====
// store sequencer: set memory, way match, replacement and result register
`timescale 1ns / 1ps
module hfmc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_o,
  input  hfmc_pkg::queue_item_t pop_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hfmc_pkg::result_t     out_res_o
);
  import hfmc_pkg::*;

  back_state_e         state_q, state_d;
  queue_item_t         cur_q;
  row_t                mem [SETS];
  row_t                rd_row_q;
  logic                rd_valid_q;
  logic [SETS-1:0]     row_valid_q;
  logic [OCC_W-1:0]    occ_q;
  result_t             res_q;
  logic                out_valid_q;
  logic                done;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) state_d = BK_EVAL;
      end
      BK_EVAL: begin
        if (!out_valid_q || out_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o = 1'b0;
    done  = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = pop_valid_i;
      BK_EVAL: done  = !out_valid_q || out_ready_i;
      default: begin
        pop_o = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  // way match and replacement choice
  row_t                row, new_row;
  logic [WAYS-1:0]     match, empty;
  logic [WAY_BITS-1:0] fm_idx, fe_idx, dest;
  logic                any_match, any_empty, is_ins;
  result_t             res_d;

  always_comb begin
    row = rd_valid_q ? rd_row_q : '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (row.tag_first[w] == cur_q.item.key_prefix) &&
                 (row.tag_second[w] == cur_q.item.key_suffix);
      empty[w] = (row.tag_first[w] == 64'd0);
    end
    fm_idx = '0;
    fe_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) fm_idx = WAY_BITS'(w);
      if (empty[w]) fe_idx = WAY_BITS'(w);
    end
    any_match = |match;
    any_empty = |empty;
    is_ins    = (cur_q.item.op == OP_INSERT) && !cur_q.key_zero;

    if (any_match) begin
      dest = fm_idx;
    end else if (any_empty) begin
      dest = fe_idx;
    end else begin
      dest = cur_q.evict_way;
    end

    new_row                  = row;
    new_row.tag_first[dest]  = cur_q.item.key_prefix;
    new_row.tag_second[dest] = cur_q.item.key_suffix;
    new_row.count[dest]      = {cur_q.item.value_high, cur_q.item.value_low};

    res_d.hit = (cur_q.item.op == OP_LOOKUP) && !cur_q.key_zero && any_match;
    res_d.found_low  = res_d.hit ? row.count[fm_idx][63:0]   : 64'd0;
    res_d.found_high = res_d.hit ? row.count[fm_idx][127:64] : 64'd0;
    res_d.evicted    = is_ins && !any_match && !any_empty;
    // a way filled from empty raises occupancy
    if (is_ins && !any_match && any_empty && (occ_q != OCC_MAX)) begin
      res_d.entries_used = occ_q + 1'b1;
    end else begin
      res_d.entries_used = occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      row_valid_q <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done && is_ins) row_valid_q[cur_q.set_idx] <= 1'b1;
      if (done) begin
        occ_q       <= res_d.entries_used;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // set memory: one row per set, read registered, written back whole on an insert
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_row_q   <= mem[pop_item_i.set_idx];
      rd_valid_q <= row_valid_q[pop_item_i.set_idx];
      cur_q      <= pop_item_i;
    end
    if (done && is_ins) mem[cur_q.set_idx] <= new_row;
    if (done) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule
